### hw/rtl/beep_pattern_sequencer_unit_defines.svh
// ---------------------------------------------------------------------------
// Beep pattern sequencer assertion macros
// Clocked on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef BEEP_PATTERN_SEQUENCER_UNIT_DEFINES_SVH
`define BEEP_PATTERN_SEQUENCER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define BPS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/bps_pkg.sv
// ---------------------------------------------------------------------------
// bps_pkg
// Shared types and constants of the beep pattern sequencer.
// ---------------------------------------------------------------------------
package bps_pkg;

  localparam int unsigned DIV_W    = 24;  // period (16b) * volume (8b)
  localparam int unsigned DIV_CNTW = $clog2(DIV_W + 1);

  localparam logic [7:0]  VOLUME_FULL = 8'd100;

  // divide by 100 as (x >> 2) * ceil(2^27 / 25) >> 27, exact for 24-bit x
  localparam logic [22:0] DUTY_RECIP = 23'd5368710;
  localparam int unsigned DUTY_SHIFT = 27;

  // input action codes
  localparam logic ACT_TICK  = 1'b0;
  localparam logic ACT_START = 1'b1;

  // volume modes; anything above rising counts as falling
  localparam logic [1:0] DIR_CONST = 2'd0;
  localparam logic [1:0] DIR_RISE  = 2'd1;

  // configuration register indexes
  localparam logic CFG_PWM_PERIOD  = 1'b0;
  localparam logic CFG_START_DELAY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP_GO,
    ST_STEP_WAIT,
    ST_MUL,
    ST_SCALE,
    ST_CLAMP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [7:0]       divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

### hw/rtl/bps_if.sv
// ---------------------------------------------------------------------------
// bps_in_if / bps_out_if
// Valid/ready channels for start/tick items and result items.
// ---------------------------------------------------------------------------
interface bps_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [7:0]  repeat_count;
  logic [15:0] on_ticks;
  logic [15:0] off_ticks;
  logic [1:0]  direction;

  modport source (output valid, action, repeat_count, on_ticks, off_ticks, direction,
                  input ready);
  modport sink   (input valid, action, repeat_count, on_ticks, off_ticks, direction,
                  output ready);
endinterface

interface bps_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] duty;
  logic        tone_on;
  logic        busy_res;

  modport source (output valid, duty, tone_on, busy_res, input ready);
  modport sink   (input valid, duty, tone_on, busy_res, output ready);
endinterface

### hw/rtl/beep_pattern_sequencer_unit.sv
// ---------------------------------------------------------------------------
// beep_pattern_sequencer_unit
// Ticks and constant-volume starts go straight to the result stage; a start
// in rising/falling mode first runs the 24-step serial divider for the volume
// step; a tone-on event passes product, scaling by 1/100 and clamp. Each item
// also waits while the result register is still full. One item at a time.
// Reset (sync, rst_n low): idle, no pattern, duty 0, pwm_period 16000, delay 10.
// ---------------------------------------------------------------------------
module beep_pattern_sequencer_unit
  import bps_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  bps_in_if.sink      in_ch,
  bps_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [15:0] cfg_wdata
);

  // -------------------------------------------------------------------------
  // Configuration registers; to be written only while the block is idle, which the block does not enforce.
  // -------------------------------------------------------------------------
  logic [15:0] pwm_period_r;
  logic [15:0] start_delay_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pwm_period_r  <= 16'd16000;
      start_delay_r <= 16'd10;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_PWM_PERIOD:  pwm_period_r  <= cfg_wdata;
        CFG_START_DELAY: start_delay_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // -------------------------------------------------------------------------
  // Pattern state
  // -------------------------------------------------------------------------
  state_t      state_r, state_nxt;
  logic        running_r;
  logic        next_is_tone_r;
  logic [7:0]  repeats_left_r;
  logic [15:0] tone_time_r;
  logic [15:0] gap_time_r;
  logic [1:0]  mode_r;
  logic [7:0]  volume_r;
  logic [6:0]  volume_step_r;
  logic [15:0] countdown_r;
  logic [15:0] current_interval_r;
  logic [15:0] duty_value_r;
  logic [DIV_W-1:0] prod_r;
  logic [17:0] scaled_r;

  logic        out_valid_r;
  logic [15:0] out_duty_r;
  logic        out_tone_r;
  logic        out_busy_r;

  div_req_t    div_req;
  div_rsp_t    div_rsp;

  logic        in_fire;
  logic        out_free;
  logic        fire_event;
  logic        is_tone_event;
  logic [7:0]  vol_upd;
  logic [7:0]  rep_dec;
  logic [15:0] ev_interval;
  logic [7:0]  step_divisor;
  logic [44:0] recip_prod;
  logic [15:0] duty_sat;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  // an event fires when the countdown runs out on a tick of a running pattern
  assign fire_event    = (in_ch.action == ACT_TICK) && running_r && (countdown_r <= 16'd1);
  assign is_tone_event = fire_event && (repeats_left_r != 8'd0) && next_is_tone_r;
  assign rep_dec       = repeats_left_r - 8'd1;

  always_comb begin
    case (mode_r)
      DIR_CONST: vol_upd = volume_r;
      DIR_RISE:  vol_upd = volume_r + {1'b0, volume_step_r};
      default:   vol_upd = volume_r - {1'b0, volume_step_r};
    endcase
  end

  // zero on/off time keeps the interval used before
  assign ev_interval  = next_is_tone_r ? tone_time_r : gap_time_r;
  assign step_divisor = (repeats_left_r == 8'd0) ? 8'd1 : repeats_left_r;

  // product / 100 by reciprocal: drop two bits, then / 25 by multiply and shift
  assign recip_prod = {23'd0, prod_r[DIV_W-1:2]} * {22'd0, DUTY_RECIP};

  // duty saturates at the period (only when volume exceeds full scale)
  assign duty_sat = (scaled_r > {2'b00, pwm_period_r}) ? pwm_period_r : scaled_r[15:0];

  // -------------------------------------------------------------------------
  // Sequencer: next state
  // -------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_ch.action == ACT_START)
            state_nxt = (in_ch.direction == DIR_CONST) ? ST_DONE : ST_STEP_GO;
          else if (is_tone_event)
            state_nxt = ST_MUL;
          else
            state_nxt = ST_DONE;
        end
      end
      ST_STEP_GO:   state_nxt = ST_STEP_WAIT;
      ST_STEP_WAIT: if (div_rsp.done) state_nxt = ST_DONE;
      ST_MUL:       state_nxt = ST_SCALE;
      ST_SCALE:     state_nxt = ST_CLAMP;
      ST_CLAMP:     state_nxt = ST_DONE;
      ST_DONE:      if (out_free) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // -------------------------------------------------------------------------
  // Sequencer: outputs (handshake and divider request)
  // -------------------------------------------------------------------------
  always_comb begin
    in_ch.ready      = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = {{(DIV_W-8){1'b0}}, VOLUME_FULL};
    div_req.divisor  = step_divisor;
    case (state_r)
      ST_IDLE:    in_ch.ready = 1'b1;
      ST_STEP_GO: div_req.start = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // -------------------------------------------------------------------------
  // Pattern datapath
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r          <= 1'b0;
      next_is_tone_r     <= 1'b0;
      repeats_left_r     <= '0;
      tone_time_r        <= '0;
      gap_time_r         <= '0;
      mode_r             <= DIR_CONST;
      volume_r           <= '0;
      volume_step_r      <= '0;
      countdown_r        <= '0;
      current_interval_r <= '0;
      duty_value_r       <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_fire && in_ch.action == ACT_START) begin
            // a start cancels any running pattern; duty stays as driven
            running_r          <= 1'b1;
            next_is_tone_r     <= 1'b1;
            repeats_left_r     <= in_ch.repeat_count;
            tone_time_r        <= in_ch.on_ticks;
            gap_time_r         <= in_ch.off_ticks;
            mode_r             <= in_ch.direction;
            countdown_r        <= start_delay_r;
            current_interval_r <= start_delay_r;
            if (in_ch.direction == DIR_CONST)
              volume_r <= VOLUME_FULL;
          end else if (in_fire && running_r) begin
            if (!fire_event) begin
              countdown_r <= countdown_r - 16'd1;
            end else if (repeats_left_r == 8'd0) begin
              running_r <= 1'b0;
            end else if (next_is_tone_r) begin
              next_is_tone_r <= 1'b0;
              volume_r       <= vol_upd;
              if (ev_interval != 16'd0) begin
                current_interval_r <= ev_interval;
                countdown_r        <= ev_interval;
              end else begin
                countdown_r <= current_interval_r;
              end
            end else begin
              duty_value_r   <= '0;
              repeats_left_r <= rep_dec;
              if (rep_dec == 8'd0) begin
                running_r <= 1'b0;
              end else begin
                next_is_tone_r <= 1'b1;
                if (ev_interval != 16'd0) begin
                  current_interval_r <= ev_interval;
                  countdown_r        <= ev_interval;
                end else begin
                  countdown_r <= current_interval_r;
                end
              end
            end
          end
        end
        ST_STEP_WAIT: begin
          if (div_rsp.done) begin
            volume_step_r <= div_rsp.quotient[6:0];
            if (mode_r == DIR_RISE)
              volume_r <= '0;
            else
              volume_r <= VOLUME_FULL + {1'b0, div_rsp.quotient[6:0]};
          end
        end
        ST_CLAMP: duty_value_r <= duty_sat;
        default: ;
      endcase
    end
  end

  // 16x8 product, then the scaled quotient, each registered
  always_ff @(posedge clk) begin
    if (state_r == ST_MUL)
      prod_r <= DIV_W'(pwm_period_r) * DIV_W'(volume_r);
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_SCALE)
      scaled_r <= recip_prod[DUTY_SHIFT +: 18];
  end

  bps_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // -------------------------------------------------------------------------
  // Result register: holds one result until its transfer completes
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_free) begin
      out_duty_r <= duty_value_r;
      out_tone_r <= (duty_value_r != 16'd0);
      out_busy_r <= running_r;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.duty     = out_duty_r;
  assign out_ch.tone_on  = out_tone_r;
  assign out_ch.busy_res = out_busy_r;

endmodule

### hw/rtl/bps_div.sv
// ---------------------------------------------------------------------------
// bps_div
// Restoring radix-2 divider, one quotient bit per cycle, 8-bit divisor.
// ---------------------------------------------------------------------------
module bps_div
  import bps_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [DIV_CNTW-1:0] cnt_r, cnt_nxt;
  logic [DIV_W-1:0]    quo_r, quo_nxt;
  logic [7:0]          rem_r, rem_nxt;
  logic [7:0]          dvs_r, dvs_nxt;
  logic [8:0]          rem_sh;
  logic [8:0]          diff;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    rem_sh   = {rem_r, quo_r[DIV_W-1]};
    diff     = rem_sh - {1'b0, dvs_r};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNTW'(DIV_W);
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, dvs_r}) begin
        rem_nxt = diff[7:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[7:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_CNTW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

### hw/rtl/bps_checker.sv
// ---------------------------------------------------------------------------
// bps_checker
// Port-level checks of the beep pattern sequencer.
// ---------------------------------------------------------------------------
`include "beep_pattern_sequencer_unit_defines.svh"

module bps_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_duty,
  input logic        out_tone_on
);

  // a pending result is not dropped
  `BPS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped before transfer")

  // one item at a time: no accept right after an accept
  `BPS_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "input accepted back to back")

  // tone flag follows the duty value
  `BPS_ASSERT_NOW(a_tone_duty, out_valid, out_tone_on == (out_duty != 16'd0), "tone_on mismatch")

endmodule

bind beep_pattern_sequencer_unit bps_checker u_bps_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_duty    (out_ch.duty),
  .out_tone_on (out_ch.tone_on)
);

### sim/tb_beep_pattern_sequencer_unit.sv
// ---------------------------------------------------------------------------
// tb_beep_pattern_sequencer_unit
// Self-checking bench for the buzzer beep sequencer. A table of directed
// starts and ticks is followed by random beep patterns under several
// period/delay settings. Every accepted item is run through a cycle-free
// model of the sequencer, and the results coming out are compared in order.
// ---------------------------------------------------------------------------
module tb_beep_pattern_sequencer_unit;
  import bps_pkg::*;

  // Falling mode has no package name; code three behaves as falling.
  localparam logic [1:0]  DIR_FALL    = 2'd2;
  localparam logic [1:0]  DIR_SPARE   = 2'd3;
  localparam logic [15:0] DUTY_MAX    = 16'hFFFF;
  localparam int unsigned SETTLE_CYC  = 40;   // covers the slowest item, a rising/falling start
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned N_PHASES    = 7;

  typedef struct packed {
    logic        action;
    logic [7:0]  repeat_count;
    logic [15:0] on_ticks;
    logic [15:0] off_ticks;
    logic [1:0]  direction;
  } beep_item_t;

  localparam int unsigned ITEM_W = $bits(beep_item_t);

  typedef struct packed {
    logic [15:0] duty;
    logic        tone_on;
    logic        busy;
  } buzzer_out_t;

  typedef struct packed {
    beep_item_t  item;
    logic        typed;   // 1: want is written out below, else from the model
    buzzer_out_t want;
  } directed_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_addr;
  logic [15:0] cfg_wdata;

  bps_in_if  in_ch ();
  bps_out_if out_ch ();

  beep_pattern_sequencer_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // -------------------------------------------------------------------------
  // Sequencer model state (widths as in the block)
  // -------------------------------------------------------------------------
  logic [15:0] period_q, delay_q;
  logic        seq_running, tone_next;
  logic [7:0]  reps;
  logic [15:0] on_t, off_t;
  logic [1:0]  vol_mode;
  logic [7:0]  vol;
  logic [6:0]  vstep;
  logic [15:0] cnt_dn, interval;
  logic [15:0] duty_q;

  buzzer_out_t buzzer_out_q[$];   // outputs still owed by the block
  int unsigned mismatch_count = 0;
  int unsigned burst_left     = 0;
  bit          gaps_on        = 1'b1;
  bit          hold_req       = 1'b0;

  // Advance the model by one item and return the outputs that follow it.
  task automatic sequence_buzzer(input beep_item_t it, output buzzer_out_t r);
    int unsigned step_q;
    logic [23:0] scaled;
    logic [15:0] next_iv;
    bit          rearm;
    rearm = 1'b0;
    next_iv = '0;
    if (it.action == ACT_START) begin
      // start always wins, even over a running pattern
      tone_next = 1'b1;
      on_t      = it.on_ticks;
      off_t     = it.off_ticks;
      reps      = it.repeat_count;
      vol_mode  = it.direction;
      if (it.direction == DIR_CONST) begin
        vol = VOLUME_FULL;          // step left as it was
      end else begin
        step_q = VOLUME_FULL / ((it.repeat_count == 8'd0) ? 8'd1 : it.repeat_count);
        vstep  = step_q[6:0];
        vol    = (it.direction == DIR_RISE) ? 8'd0 : VOLUME_FULL + {1'b0, vstep};
      end
      interval    = delay_q;
      cnt_dn      = delay_q;
      seq_running = 1'b1;
    end else if (seq_running) begin
      if (cnt_dn > 16'd1) begin
        cnt_dn = cnt_dn - 16'd1;
      end else if (reps == 8'd0) begin
        seq_running = 1'b0;         // zero repeats: end, duty untouched
      end else if (tone_next) begin
        tone_next = 1'b0;
        if (vol_mode == DIR_RISE) vol = vol + vstep;
        else if (vol_mode != DIR_CONST) vol = vol - vstep;
        scaled = period_q * vol;
        scaled = scaled / VOLUME_FULL;
        if (scaled > period_q) scaled = period_q;
        duty_q  = scaled[15:0];
        next_iv = on_t;
        rearm   = 1'b1;
      end else begin
        duty_q = '0;
        reps   = reps - 8'd1;
        if (reps == 8'd0) begin
          seq_running = 1'b0;
        end else begin
          tone_next = 1'b1;
          next_iv   = off_t;
          rearm     = 1'b1;
        end
      end
      if (rearm) begin
        if (next_iv != 16'd0) interval = next_iv;   // zero keeps the old one
        cnt_dn = interval;
      end
    end
    r.duty    = duty_q;
    r.tone_on = (duty_q != 16'd0);
    r.busy    = seq_running;
  endtask

  // -------------------------------------------------------------------------
  // Sender side
  // -------------------------------------------------------------------------
  task automatic offer(input beep_item_t it, input logic typed, input buzzer_out_t want);
    buzzer_out_t got;
    in_ch.valid        <= 1'b1;
    in_ch.action       <= it.action;
    in_ch.repeat_count <= it.repeat_count;
    in_ch.on_ticks     <= it.on_ticks;
    in_ch.off_ticks    <= it.off_ticks;
    in_ch.direction    <= it.direction;
    do @(posedge clk); while (!in_ch.ready);
    sequence_buzzer(it, got);
    buzzer_out_q.push_back(typed ? want : got);
  endtask

  // Bursts of items offered back to back, then a random gap.
  task automatic sender_gap();
    int unsigned n;
    if (!gaps_on) return;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      n = $urandom_range(1, 8);
      in_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Let everything owed come out, then give the block time to go quiet.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (buzzer_out_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == CFG_PWM_PERIOD) period_q = value;
    else delay_q = value;
  endtask

  function automatic logic [15:0] pick_ticks();
    return ($urandom_range(0, 15) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 4));
  endfunction

  // A start with random content followed by a run of ticks; short runs
  // leave the pattern to be cut off by the next start.
  task automatic random_pattern(inout int unsigned counted);
    beep_item_t  it;
    int unsigned n_ticks;
    int unsigned k;
    it.action       = ACT_START;
    it.repeat_count = ($urandom_range(0, 15) == 0) ? 8'($urandom())
                                                   : 8'($urandom_range(0, 6));
    it.on_ticks     = pick_ticks();
    it.off_ticks    = pick_ticks();
    it.direction    = 2'($urandom());
    offer(it, 1'b0, '0);
    sender_gap();
    counted++;
    n_ticks = $urandom_range(2, 45);
    for (k = 0; k < n_ticks; k++) begin
      it = beep_item_t'(ITEM_W'({$urandom(), $urandom()}));
      it.action = ACT_TICK;   // other fields are don't-care on a tick
      counted++;
      offer(it, 1'b0, '0);
      sender_gap();
    end
  endtask

  // -------------------------------------------------------------------------
  // Directed table, run with period 65535 and a delay of one tick
  // -------------------------------------------------------------------------
  directed_row_t directed_rows [0:24] = '{
    // tick while idle: nothing moves
    '{'{ACT_TICK,  8'd0,   16'd0,     16'd0,     DIR_CONST}, 1'b1, '{16'd0,    1'b0, 1'b0}},
    // constant volume, zero on/off times keep the delay as interval
    '{'{ACT_START, 8'd2,   16'd0,     16'd0,     DIR_CONST}, 1'b1, '{16'd0,    1'b0, 1'b1}},
    '{'{ACT_TICK,  8'd0,   16'd0,     16'd0,     DIR_CONST}, 1'b1, '{DUTY_MAX, 1'b1, 1'b1}},
    '{'{ACT_TICK,  8'd0,   16'd0,     16'd0,     DIR_CONST}, 1'b1, '{16'd0,    1'b0, 1'b1}},
    '{'{ACT_TICK,  8'd0,   16'd0,     16'd0,     DIR_CONST}, 1'b1, '{DUTY_MAX, 1'b1, 1'b1}},
    // last tone-off ends the pattern
    '{'{ACT_TICK,  8'd0,   16'd0,     16'd0,     DIR_CONST}, 1'b1, '{16'd0,    1'b0, 1'b0}},
    '{'{ACT_TICK,  8'hFF,  16'hFFFF,  16'hFFFF,  DIR_SPARE}, 1'b1, '{16'd0,    1'b0, 1'b0}},
    // zero repeats: first event just stops
    '{'{ACT_START, 8'd0,   16'd3,     16'd3,     DIR_RISE},  1'b1, '{16'd0,    1'b0, 1'b1}},
    '{'{ACT_TICK,  8'd0,   16'd0,     16'd0,     DIR_CONST}, 1'b1, '{16'd0,    1'b0, 1'b0}},
    // largest count and times, falling with a zero step
    '{'{ACT_START, 8'd255, 16'hFFFF,  16'hFFFF,  DIR_FALL},  1'b1, '{16'd0,    1'b0, 1'b1}},
    '{'{ACT_TICK,  8'd0,   16'd0,     16'd0,     DIR_CONST}, 1'b1, '{DUTY_MAX, 1'b1, 1'b1}},
    // restart while sounding: duty holds until the next event
    '{'{ACT_START, 8'd3,   16'd1,     16'd1,     DIR_SPARE}, 1'b1, '{DUTY_MAX, 1'b1, 1'b1}},
    '{'{ACT_TICK,  8'd0,   16'd0,     16'd0,     DIR_CONST}, 1'b0, '0},
    '{'{ACT_TICK,  8'd0,   16'd0,     16'd0,     DIR_CONST}, 1'b0, '0},
    '{'{ACT_TICK,  8'd0,   16'd0,     16'd0,     DIR_CONST}, 1'b0, '0},
    '{'{ACT_TICK,  8'd0,   16'd0,     16'd0,     DIR_CONST}, 1'b0, '0},
    '{'{ACT_TICK,  8'd0,   16'd0,     16'd0,     DIR_CONST}, 1'b0, '0},
    '{'{ACT_TICK,  8'd0,   16'd0,     16'd0,     DIR_CONST}, 1'b0, '0},
    // rising, four steps of 25, zero off time
    '{'{ACT_START, 8'd4,   16'd2,     16'd0,     DIR_RISE},  1'b0, '0},
    '{'{ACT_TICK,  8'd0,   16'd0,     16'd0,     DIR_CONST}, 1'b0, '0},
    '{'{ACT_TICK,  8'd0,   16'd0,     16'd0,     DIR_CONST}, 1'b0, '0},
    '{'{ACT_TICK,  8'd0,   16'd0,     16'd0,     DIR_CONST}, 1'b0, '0},
    '{'{ACT_TICK,  8'd0,   16'd0,     16'd0,     DIR_CONST}, 1'b0, '0},
    '{'{ACT_TICK,  8'd0,   16'd0,     16'd0,     DIR_CONST}, 1'b0, '0},
    // constant start keeps the old step
    '{'{ACT_START, 8'd1,   16'd0,     16'hFFFF,  DIR_CONST}, 1'b0, '0}
  };

  // -------------------------------------------------------------------------
  // Stimulus
  // -------------------------------------------------------------------------
  initial begin : stimulus
    logic [15:0] phase_period [N_PHASES];
    logic [15:0] phase_delay  [N_PHASES];
    int unsigned phase_quota  [N_PHASES];
    int unsigned counted;
    int unsigned p;
    beep_item_t  it;

    phase_period = '{16'd16000, 16'd0, 16'hFFFF, 16'd0, 16'd0, 16'd40000, 16'd0};
    phase_delay  = '{16'd10, 16'd2, 16'd0, 16'd3, 16'd1, 16'hFFFF, 16'd0};
    // the long-delay phase only checks the countdown holds, so keep it short
    phase_quota  = '{95, 95, 95, 95, 95, 20, 95};

    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_addr           <= CFG_PWM_PERIOD;
    cfg_wdata          <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.action       <= ACT_TICK;
    in_ch.repeat_count <= '0;
    in_ch.on_ticks     <= '0;
    in_ch.off_ticks    <= '0;
    in_ch.direction    <= DIR_CONST;

    period_q    = 16'd16000;
    delay_q     = 16'd10;
    seq_running = 1'b0;
    tone_next   = 1'b0;
    reps        = '0;
    on_t        = '0;
    off_t       = '0;
    vol_mode    = DIR_CONST;
    vol         = '0;
    vstep       = '0;
    cnt_dn      = '0;
    interval    = '0;
    duty_q      = '0;

    phase_period[3] = 16'($urandom());
    phase_period[4] = 16'($urandom());
    phase_period[6] = 16'($urandom());
    phase_delay[6]  = 16'($urandom_range(0, 6));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    write_reg(CFG_PWM_PERIOD, DUTY_MAX);
    write_reg(CFG_START_DELAY, 16'd1);
    foreach (directed_rows[i]) begin
      offer(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
      sender_gap();
    end
    settle();

    for (p = 0; p < N_PHASES; p++) begin
      write_reg(CFG_PWM_PERIOD, phase_period[p]);
      write_reg(CFG_START_DELAY, phase_delay[p]);
      gaps_on = (p != 0);          // first phase runs flat out
      if (p == 1 || p == 4) hold_req = 1'b1;
      counted = 0;
      while (counted < phase_quota[p]) begin
        if ($urandom_range(0, 9) < 8) begin
          random_pattern(counted);
        end else begin
          // noise: any action, any content
          it = beep_item_t'(ITEM_W'({$urandom(), $urandom()}));
          counted++;
          offer(it, 1'b0, '0);
          sender_gap();
        end
      end
      settle();                    // sender waits for every result
    end

    if (mismatch_count == 0 && buzzer_out_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // -------------------------------------------------------------------------
  // Receiver: ready follows a 16-bit pattern, re-rolled after a random span
  // (a quarter of the time all ones). On request it holds off for a
  // long stretch so the block backs up and stalls its input.
  // -------------------------------------------------------------------------
  initial begin : receiver
    logic [15:0] pat;
    int unsigned span;
    int unsigned pos;
    pat  = 16'hFFFF;
    span = 0;
    pos  = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        if (span == 0) begin
          span = $urandom_range(20, 80);
          pat  = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom()) | 16'h0001);
        end
        span--;
        out_ch.ready <= pat[pos];
        pos = (pos + 1) % 16;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Result check, in order, on every output transfer
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    buzzer_out_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (buzzer_out_q.size() == 0) begin
        $error("unexpected transfer: duty %0d tone_on %0b busy_res %0b",
               out_ch.duty, out_ch.tone_on, out_ch.busy_res);
        mismatch_count++;
      end else begin
        want = buzzer_out_q.pop_front();
        if (out_ch.duty !== want.duty) begin
          $error("duty: expected %0d, got %0d", want.duty, out_ch.duty);
          mismatch_count++;
        end
        if (out_ch.tone_on !== want.tone_on) begin
          $error("tone_on: expected %0b, got %0b", want.tone_on, out_ch.tone_on);
          mismatch_count++;
        end
        if (out_ch.busy_res !== want.busy) begin
          $error("busy_res: expected %0b, got %0b", want.busy, out_ch.busy_res);
          mismatch_count++;
        end
      end
    end
  end

  // Hard stop.
  initial begin : watchdog
    #(5_000_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
